// File: design/tgi_pkg.sv
// ---------------------------------------------------------------------------
// tgi_pkg
// Shared types and constants of the trilinear grid interpolator.
// ---------------------------------------------------------------------------
package tgi_pkg;

    localparam int ACC_W = 84;
    localparam logic [16:0] W_ONE = 17'h10000;

    typedef enum logic [2:0] {
        OP_ALT_LOAD = 3'd0,
        OP_LON_LOAD = 3'd1,
        OP_LAT_LOAD = 3'd2,
        OP_TBL_LOAD = 3'd3,
        OP_QUERY    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        CFG_ALT_COUNT = 2'd0,
        CFG_LON_COUNT = 2'd1,
        CFG_LAT_COUNT = 2'd2,
        CFG_LON_WRAP  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        AX_ALT = 2'd0,
        AX_LON = 2'd1,
        AX_LAT = 2'd2
    } t_axis;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AX_RD,
        S_AX_CMP,
        S_AX_EVAL,
        S_DIV,
        S_MAC_ADDR,
        S_MAC_WP,
        S_MAC_LO,
        S_MAC_HI,
        S_MAC_ACC,
        S_ROUND
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [4:0]         alt_index;
        logic [4:0]         lon_index;
        logic [3:0]         lat_index;
        logic signed [31:0] load_value;
        logic signed [31:0] query_alt;
        logic signed [31:0] query_lat;
        logic signed [31:0] query_lon;
    } t_item;

    typedef struct packed {
        logic [5:0]  alt_count;
        logic [5:0]  lon_count;
        logic [4:0]  lat_count;
        logic [30:0] lon_wrap_span;
    } t_cfg;

    typedef struct packed {
        logic  avail;
        t_item head;
    } t_queue_out;

endpackage

// File: design/trilinear_grid_interpolator.sv
// ---------------------------------------------------------------------------
// trilinear_grid_interpolator
// Trilinear interpolation over a loaded non-uniform altitude/lon/lat grid.
// ---------------------------------------------------------------------------
// Usage: raise i_start with the item fields; the item is taken on a clock
// edge where o_busy is low. Operations 0..2 load an axis point, 3 loads a
// table value, 4 runs a query; loads give no result. A query result shows on
// o_interp_value with o_done high for one cycle; the receiver cannot stall.
// Registers are written through i_cfg_valid/o_cfg_ready (always ready); the
// user must write them only while the block is idle, as the block does not
// enforce this. A two-entry queue sits between the accepting front and the
// executing back end, so o_busy rises only when it is full. A query scans
// each axis in turn (one axis memory read and compare per point), runs the
// radix-2 divider for each axis that needs a division, and then runs eight
// corner multiply-accumulates.
// Reset clears the control state and the registers to their reset values;
// axis and table contents stay undefined until loaded.
// ---------------------------------------------------------------------------
module trilinear_grid_interpolator #(
    parameter int ALT_POINTS = 32,
    parameter int LON_POINTS = 32,
    parameter int LAT_POINTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_operation,
    input  logic [4:0]         i_alt_index,
    input  logic [4:0]         i_lon_index,
    input  logic [3:0]         i_lat_index,
    input  logic signed [31:0] i_load_value,
    input  logic signed [31:0] i_query_alt,
    input  logic signed [31:0] i_query_lat,
    input  logic signed [31:0] i_query_lon,
    output logic               o_done,
    output logic signed [31:0] o_interp_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    tgi_pkg::t_cfg       r_cfg;
    tgi_pkg::t_item      item;
    tgi_pkg::t_queue_out queue;
    logic                pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alt_count     <= 6'd1;
            r_cfg.lon_count     <= 6'd1;
            r_cfg.lat_count     <= 5'd1;
            r_cfg.lon_wrap_span <= 31'd1474560;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (tgi_pkg::t_cfg_idx'(i_cfg_index))
                tgi_pkg::CFG_ALT_COUNT: r_cfg.alt_count     <= i_cfg_data[5:0];
                tgi_pkg::CFG_LON_COUNT: r_cfg.lon_count     <= i_cfg_data[5:0];
                tgi_pkg::CFG_LAT_COUNT: r_cfg.lat_count     <= i_cfg_data[4:0];
                tgi_pkg::CFG_LON_WRAP:  r_cfg.lon_wrap_span <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        item.op         = tgi_pkg::t_op'(i_operation);
        item.alt_index  = i_alt_index;
        item.lon_index  = i_lon_index;
        item.lat_index  = i_lat_index;
        item.load_value = i_load_value;
        item.query_alt  = i_query_alt;
        item.query_lat  = i_query_lat;
        item.query_lon  = i_query_lon;
    end

    tgi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_item  (item),
        .o_queue (queue),
        .i_pop   (pop)
    );

    tgi_back #(
        .ALT_POINTS (ALT_POINTS),
        .LON_POINTS (LON_POINTS),
        .LAT_POINTS (LAT_POINTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_queue        (queue),
        .o_pop          (pop),
        .o_done         (o_done),
        .o_interp_value (o_interp_value)
    );

endmodule

// File: design/tgi_front.sv
// ---------------------------------------------------------------------------
// tgi_front
// Accepts items, drops unknown operations and queues the rest (two deep).
// ---------------------------------------------------------------------------
module tgi_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  tgi_pkg::t_item      i_item,
    output tgi_pkg::t_queue_out o_queue,
    input  logic                i_pop
);

    tgi_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           known_op;
    logic           push;

    assign o_busy   = (r_cnt == 2'd2);
    assign known_op = (i_item.op == tgi_pkg::OP_ALT_LOAD) || (i_item.op == tgi_pkg::OP_LON_LOAD)
                   || (i_item.op == tgi_pkg::OP_LAT_LOAD) || (i_item.op == tgi_pkg::OP_TBL_LOAD)
                   || (i_item.op == tgi_pkg::OP_QUERY);
    // unknown operations are accepted and dropped
    assign push     = i_start && !o_busy && known_op;

    assign o_queue.avail = (r_cnt != 2'd0);
    assign o_queue.head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

// File: design/tgi_div.sv
// ---------------------------------------------------------------------------
// tgi_div
// Rounded weight divider: (num * 65536 + den / 2) / den, one bit a cycle.
// ---------------------------------------------------------------------------
module tgi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quot
);

    logic [31:0] r_rem;
    logic [16:0] r_bits;
    logic [16:0] r_q;
    logic [31:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [48:0] dvd;
    logic [32:0] trial;
    logic        fits;

    // quotient never exceeds 17 bits, so the top 32 bits start below den
    assign dvd   = {1'b0, i_num, 16'b0} + 49'(i_den >> 1);
    assign trial = {r_rem, r_bits[16]};
    assign fits  = (trial >= {1'b0, r_den});

    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= dvd[48:17];
            r_bits <= dvd[16:0];
            r_den  <= i_den;
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_bits <= {r_bits[15:0], 1'b0};
            r_q    <= {r_q[15:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd17;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

// File: design/tgi_back.sv
// ---------------------------------------------------------------------------
// tgi_back
// Executes queued items: axis/table loads and the interpolation sequence.
// ---------------------------------------------------------------------------
module tgi_back #(
    parameter int ALT_POINTS = 32,
    parameter int LON_POINTS = 32,
    parameter int LAT_POINTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tgi_pkg::t_cfg       i_cfg,
    input  tgi_pkg::t_queue_out i_queue,
    output logic                o_pop,
    output logic                o_done,
    output logic signed [31:0]  o_interp_value
);

    localparam int AAW    = $clog2(ALT_POINTS);
    localparam int OAW    = $clog2(LON_POINTS);
    localparam int TAW    = $clog2(LAT_POINTS);
    localparam int IW     = (AAW > OAW) ? ((AAW > TAW) ? AAW : TAW)
                                        : ((OAW > TAW) ? OAW : TAW);
    localparam int TDEPTH = ALT_POINTS * LON_POINTS * LAT_POINTS;
    localparam int TW     = $clog2(TDEPTH);
    localparam int AW     = tgi_pkg::ACC_W;

    logic signed [31:0] r_alt_mem [ALT_POINTS];
    logic signed [31:0] r_lon_mem [LON_POINTS];
    logic signed [31:0] r_lat_mem [LAT_POINTS];
    logic signed [31:0] r_tbl_mem [TDEPTH];
    logic signed [31:0] r_alt_q;
    logic signed [31:0] r_lon_q;
    logic signed [31:0] r_lat_q;
    logic signed [31:0] r_tq;

    tgi_pkg::t_state r_state;
    tgi_pkg::t_state n_state;
    tgi_pkg::t_item  r_item;
    tgi_pkg::t_axis  r_axis;
    logic [IW-1:0]      r_i;
    logic signed [31:0] r_prev;
    logic signed [31:0] r_up;
    logic signed [31:0] r_low;
    logic [IW-1:0]      r_iup;
    logic [IW-1:0]      r_iu [3];
    logic [IW-1:0]      r_il [3];
    logic [16:0]        r_wu [3];
    logic [16:0]        r_wl [3];
    logic [2:0]         r_c;
    logic [TW-1:0]      r_taddr;
    logic [33:0]        r_wp1;
    logic [48:0]        r_wp;
    logic signed [56:0] r_plo;
    logic signed [57:0] r_phi;
    logic signed [AW-1:0] r_acc;
    logic               r_done;
    logic signed [31:0] r_value;

    logic [8:0]         alt_m1, lon_m1, lat_m1;
    logic [IW-1:0]      alt_last, lon_last, lat_last, cur_last;
    logic signed [31:0] ax_q;
    logic signed [34:0] cur_v;
    logic signed [34:0] lon_w;
    logic signed [31:0] low_v;
    logic               stop;
    logic signed [32:0] den;
    logic signed [34:0] num_raw;
    logic [31:0]        num;
    logic [IW-1:0]      il_idx;
    logic               den_le0;
    logic               v_gt_up;
    logic               need_div;
    logic               div_start;
    logic               div_done;
    logic [16:0]        div_q;
    logic               alt_we, lon_we, lat_we, tbl_we;
    logic [TW-1:0]      ld_addr;
    logic [TW-1:0]      mac_addr;
    logic [IW-1:0]      ia, io, it;
    logic [16:0]        wa, wo, wt;
    logic signed [AW-1:0] rnd;

    // effective last index per axis: a count of zero acts as one, clip at depth
    assign alt_m1 = 9'(i_cfg.alt_count) - 9'd1;
    assign lon_m1 = 9'(i_cfg.lon_count) - 9'd1;
    assign lat_m1 = 9'(i_cfg.lat_count) - 9'd1;
    assign alt_last = (i_cfg.alt_count == '0) ? '0
                    : (int'(i_cfg.alt_count) > ALT_POINTS) ? IW'(ALT_POINTS - 1) : IW'(alt_m1);
    assign lon_last = (i_cfg.lon_count == '0) ? '0
                    : (int'(i_cfg.lon_count) > LON_POINTS) ? IW'(LON_POINTS - 1) : IW'(lon_m1);
    assign lat_last = (i_cfg.lat_count == '0) ? '0
                    : (int'(i_cfg.lat_count) > LAT_POINTS) ? IW'(LAT_POINTS - 1) : IW'(lat_m1);

    assign lon_w = (r_item.query_lon < 0)
                 ? 35'(r_item.query_lon) + $signed({4'b0, i_cfg.lon_wrap_span})
                 : 35'(r_item.query_lon);

    always_comb begin
        case (r_axis)
            tgi_pkg::AX_ALT: begin
                ax_q = r_alt_q; cur_v = 35'(r_item.query_alt); cur_last = alt_last;
            end
            tgi_pkg::AX_LON: begin
                ax_q = r_lon_q; cur_v = lon_w; cur_last = lon_last;
            end
            default: begin
                ax_q = r_lat_q; cur_v = 35'(r_item.query_lat); cur_last = lat_last;
            end
        endcase
    end

    // upper-bound scan: stop at the first point above v, or at the last one
    assign low_v = (r_i == '0) ? ax_q : r_prev;
    assign stop  = (35'(ax_q) > cur_v) || (r_i == cur_last);

    assign den      = 33'(r_up) - 33'(r_low);
    assign num_raw  = cur_v - 35'(r_low);
    assign il_idx   = (r_iup == '0) ? '0 : r_iup - 1'b1;
    assign den_le0  = (den <= 0);
    assign v_gt_up  = (cur_v > 35'(r_up));
    assign need_div = !den_le0 && !v_gt_up;
    assign num      = (num_raw < 0) ? '0
                    : (num_raw > 35'(den)) ? den[31:0] : num_raw[31:0];

    tgi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den[31:0]),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // corner select: bit 0 altitude, bit 1 longitude, bit 2 latitude
    assign ia = r_c[0] ? r_il[0] : r_iu[0];
    assign io = r_c[1] ? r_il[1] : r_iu[1];
    assign it = r_c[2] ? r_il[2] : r_iu[2];
    assign wa = r_c[0] ? r_wl[0] : r_wu[0];
    assign wo = r_c[1] ? r_wl[1] : r_wu[1];
    assign wt = r_c[2] ? r_wl[2] : r_wu[2];
    assign mac_addr = TW'(ia) * TW'(LON_POINTS * LAT_POINTS) + TW'(io) * TW'(LAT_POINTS)
                    + TW'(it);
    assign ld_addr  = TW'(i_queue.head.alt_index) * TW'(LON_POINTS * LAT_POINTS)
                    + TW'(i_queue.head.lon_index) * TW'(LAT_POINTS)
                    + TW'(i_queue.head.lat_index);

    assign rnd = r_acc + (AW'(1) <<< 47);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tgi_pkg::S_IDLE: begin
                if (i_queue.avail && i_queue.head.op == tgi_pkg::OP_QUERY) begin
                    n_state = tgi_pkg::S_AX_RD;
                end
            end
            tgi_pkg::S_AX_RD:  n_state = tgi_pkg::S_AX_CMP;
            tgi_pkg::S_AX_CMP: n_state = stop ? tgi_pkg::S_AX_EVAL : tgi_pkg::S_AX_RD;
            tgi_pkg::S_AX_EVAL: begin
                if (need_div) begin
                    n_state = tgi_pkg::S_DIV;
                end else begin
                    n_state = (r_axis == tgi_pkg::AX_LAT) ? tgi_pkg::S_MAC_ADDR
                                                          : tgi_pkg::S_AX_RD;
                end
            end
            tgi_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = (r_axis == tgi_pkg::AX_LAT) ? tgi_pkg::S_MAC_ADDR
                                                          : tgi_pkg::S_AX_RD;
                end
            end
            tgi_pkg::S_MAC_ADDR: n_state = tgi_pkg::S_MAC_WP;
            tgi_pkg::S_MAC_WP:   n_state = tgi_pkg::S_MAC_LO;
            tgi_pkg::S_MAC_LO:   n_state = tgi_pkg::S_MAC_HI;
            tgi_pkg::S_MAC_HI:   n_state = tgi_pkg::S_MAC_ACC;
            tgi_pkg::S_MAC_ACC: begin
                n_state = (r_c == 3'd7) ? tgi_pkg::S_ROUND : tgi_pkg::S_MAC_ADDR;
            end
            tgi_pkg::S_ROUND: n_state = tgi_pkg::S_IDLE;
            default:          n_state = tgi_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop     = 1'b0;
        div_start = 1'b0;
        alt_we    = 1'b0;
        lon_we    = 1'b0;
        lat_we    = 1'b0;
        tbl_we    = 1'b0;
        case (r_state)
            tgi_pkg::S_IDLE: begin
                o_pop  = i_queue.avail;
                alt_we = i_queue.avail && i_queue.head.op == tgi_pkg::OP_ALT_LOAD
                      && int'(i_queue.head.alt_index) < ALT_POINTS;
                lon_we = i_queue.avail && i_queue.head.op == tgi_pkg::OP_LON_LOAD
                      && int'(i_queue.head.lon_index) < LON_POINTS;
                lat_we = i_queue.avail && i_queue.head.op == tgi_pkg::OP_LAT_LOAD
                      && int'(i_queue.head.lat_index) < LAT_POINTS;
                tbl_we = i_queue.avail && i_queue.head.op == tgi_pkg::OP_TBL_LOAD
                      && int'(i_queue.head.alt_index) < ALT_POINTS
                      && int'(i_queue.head.lon_index) < LON_POINTS
                      && int'(i_queue.head.lat_index) < LAT_POINTS;
            end
            tgi_pkg::S_AX_EVAL: div_start = need_div;
            default: begin
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (alt_we) begin
            r_alt_mem[AAW'(i_queue.head.alt_index)] <= i_queue.head.load_value;
        end
        r_alt_q <= r_alt_mem[AAW'(r_i)];
    end

    always_ff @(posedge i_clk) begin
        if (lon_we) begin
            r_lon_mem[OAW'(i_queue.head.lon_index)] <= i_queue.head.load_value;
        end
        r_lon_q <= r_lon_mem[OAW'(r_i)];
    end

    always_ff @(posedge i_clk) begin
        if (lat_we) begin
            r_lat_mem[TAW'(i_queue.head.lat_index)] <= i_queue.head.load_value;
        end
        r_lat_q <= r_lat_mem[TAW'(r_i)];
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[ld_addr] <= i_queue.head.load_value;
        end
        r_tq <= r_tbl_mem[r_taddr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            tgi_pkg::S_IDLE: begin
                r_item <= i_queue.head;
                r_i    <= '0;
            end
            tgi_pkg::S_AX_CMP: begin
                if (stop) begin
                    r_up  <= ax_q;
                    r_low <= low_v;
                    r_iup <= r_i;
                end else begin
                    r_prev <= ax_q;
                    r_i    <= r_i + 1'b1;
                end
            end
            tgi_pkg::S_AX_EVAL: begin
                r_i <= '0;
                if (den_le0) begin
                    r_iu[r_axis] <= il_idx;
                    r_il[r_axis] <= il_idx;
                    r_wu[r_axis] <= tgi_pkg::W_ONE;
                    r_wl[r_axis] <= '0;
                end else if (v_gt_up) begin
                    r_iu[r_axis] <= r_iup;
                    r_il[r_axis] <= r_iup;
                    r_wu[r_axis] <= tgi_pkg::W_ONE;
                    r_wl[r_axis] <= '0;
                end
            end
            tgi_pkg::S_DIV: begin
                if (div_done) begin
                    r_iu[r_axis] <= r_iup;
                    r_il[r_axis] <= il_idx;
                    r_wu[r_axis] <= div_q;
                    r_wl[r_axis] <= tgi_pkg::W_ONE - div_q;
                end
            end
            tgi_pkg::S_MAC_ADDR: begin
                r_taddr <= mac_addr;
                r_wp1   <= 34'(wa) * 34'(wo);
            end
            tgi_pkg::S_MAC_WP: r_wp <= 49'(r_wp1) * 49'(wt);
            tgi_pkg::S_MAC_LO: r_plo <= r_tq * $signed({1'b0, r_wp[23:0]});
            tgi_pkg::S_MAC_HI: begin
                r_phi <= r_tq * $signed({1'b0, r_wp[48:24]});
                r_acc <= r_acc + {{(AW - 57){r_plo[56]}}, r_plo};
            end
            tgi_pkg::S_MAC_ACC: begin
                r_acc <= r_acc + {{(AW - 82){r_phi[57]}}, r_phi, 24'b0};
            end
            tgi_pkg::S_ROUND: r_value <= rnd[79:48];
            default: begin
            end
        endcase
        if (n_state == tgi_pkg::S_MAC_ADDR && r_state != tgi_pkg::S_MAC_ACC) begin
            r_acc <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgi_pkg::S_IDLE;
            r_axis  <= tgi_pkg::AX_ALT;
            r_c     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == tgi_pkg::S_ROUND);
            if (r_state == tgi_pkg::S_IDLE) begin
                r_axis <= tgi_pkg::AX_ALT;
                r_c    <= '0;
            end else if ((r_state == tgi_pkg::S_AX_EVAL && !need_div)
                      || (r_state == tgi_pkg::S_DIV && div_done)) begin
                case (r_axis)
                    tgi_pkg::AX_ALT: r_axis <= tgi_pkg::AX_LON;
                    tgi_pkg::AX_LON: r_axis <= tgi_pkg::AX_LAT;
                    default:         r_axis <= tgi_pkg::AX_LAT;
                endcase
            end else if (r_state == tgi_pkg::S_MAC_ACC) begin
                r_c <= r_c + 3'd1;
            end
        end
    end

    assign o_done         = r_done;
    assign o_interp_value = r_value;

endmodule
